// File: rtl/rbpd_pkg.sv
// Package: shared types and constants for the RGB block-pool downscaler.
`timescale 1ns / 1ps
package rbpd_pkg;
	localparam int DEF_MAX_FRAME_WIDTH = 4096;
	localparam int DEF_MAX_TILE_SIDE   = 16;
	localparam int FRAME_HEIGHT_LIMIT  = 4096;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int LANE_W     = 16;
	localparam int ACC_W      = 3 * LANE_W;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAY_ENABLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READY,
		ST_READ,
		ST_ACCUM,
		ST_DIVIDE,
		ST_GRAY
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic setup_start;  // begin computing tile/frame bounds
		logic setup_step;   // one step of the bounds division
		logic take_pixel;   // latch input pixel and evaluate position
		logic accum;        // read-modify-write of accumulator
		logic div_start;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic setup_done;
		logic active;
		logic emit;
		logic div_done;
	} dp_status_t;
endpackage

// File: rtl/rbpd_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module rbpd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/rbpd_ctrl.sv
// Controller state machine sequencing one pixel transaction at a time.
`timescale 1ns / 1ps
module rbpd_ctrl import rbpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t sts
);
	ctrl_state_t state_q, state_d;
	logic        stale_q;     // bounds need recomputing after a config write
	logic        out_valid_q; // output register holds a result

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stale_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				stale_q <= 1'b1;
			end else if (state_q == ST_SETUP && sts.setup_done) begin
				stale_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// hold off while registers are still being written
				if (cfg_we) begin
					state_d = ST_IDLE;
				end else if (stale_q) begin
					cmd.setup_start = 1'b1;
					state_d = ST_SETUP;
				end else begin
					state_d = ST_READY;
				end
			end
			ST_SETUP: begin
				cmd.setup_step = 1'b1;
				if (cfg_we) begin
					state_d = ST_IDLE; // restart with the new values
				end else if (sts.setup_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_READY: begin
				if (cfg_we) begin
					state_d = ST_IDLE;
				end else begin
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.take_pixel = 1'b1;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				// accumulator read address presented; data valid next cycle
				state_d = sts.active ? ST_ACCUM : ST_IDLE;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				if (sts.emit) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIVIDE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_GRAY;
				end
			end
			ST_GRAY: begin
				// wait here while the previous result is still held
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// File: rtl/rbpd_datapath.sv
// Datapath: counters, bounds, accumulator memory, divider and gray mix.
`timescale 1ns / 1ps
module rbpd_datapath import rbpd_pkg::*; #(
	parameter int MAX_FRAME_WIDTH = DEF_MAX_FRAME_WIDTH,
	parameter int MAX_TILE_SIDE   = DEF_MAX_TILE_SIDE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [7:0]            pixel_red,
	input  logic [7:0]            pixel_green,
	input  logic [7:0]            pixel_blue,
	output logic [7:0]            out_red,
	output logic [7:0]            out_green,
	output logic [7:0]            out_blue,
	output logic                  row_end,
	output logic                  frame_end,
	input  dp_cmd_t               cmd,
	output dp_status_t            sts
);
	localparam int FW_W   = $clog2(MAX_FRAME_WIDTH + 1);
	localparam int FH_W   = $clog2(FRAME_HEIGHT_LIMIT + 1);
	localparam int CW     = $clog2(MAX_FRAME_WIDTH);
	localparam int RW     = $clog2(FRAME_HEIGHT_LIMIT);
	localparam int TS_W   = $clog2(MAX_TILE_SIDE + 1);
	localparam int TI_W   = $clog2(MAX_TILE_SIDE);
	localparam int AREA_W = 2 * TS_W;
	// divider covers frame sizes and full lane sums
	localparam int DV_W0  = (FW_W > FH_W) ? FW_W : FH_W;
	localparam int DV_W   = (LANE_W > DV_W0) ? LANE_W : DV_W0;
	localparam int DIVSTEPS = DV_W;

	// configuration registers
	logic        pool_mode_q, gray_enable_q;
	logic [4:0]  block_width_q, block_height_q;
	logic [12:0] frame_width_q, frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_mode_q    <= 1'b0;
			gray_enable_q  <= 1'b1;
			block_width_q  <= 5'd5;
			block_height_q <= 5'd10;
			frame_width_q  <= 13'd640;
			frame_height_q <= 13'd360;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POOL_MODE:    pool_mode_q    <= cfg_data[0];
				REG_GRAY_ENABLE:  gray_enable_q  <= cfg_data[0];
				REG_BLOCK_WIDTH:  block_width_q  <= cfg_data[4:0];
				REG_BLOCK_HEIGHT: block_height_q <= cfg_data[4:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[12:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// clamped sizes
	logic [TS_W-1:0] bw, bh;
	logic [FW_W-1:0] fw;
	logic [FH_W-1:0] fh;
	always_comb begin
		if (block_width_q == '0) bw = TS_W'(1);
		else if (32'(block_width_q) > MAX_TILE_SIDE) bw = TS_W'(MAX_TILE_SIDE);
		else bw = TS_W'(block_width_q);
		if (block_height_q == '0) bh = TS_W'(1);
		else if (32'(block_height_q) > MAX_TILE_SIDE) bh = TS_W'(MAX_TILE_SIDE);
		else bh = TS_W'(block_height_q);
		if (frame_width_q == '0) fw = FW_W'(1);
		else if (32'(frame_width_q) > MAX_FRAME_WIDTH) fw = FW_W'(MAX_FRAME_WIDTH);
		else fw = FW_W'(frame_width_q);
		if (frame_height_q == '0) fh = FH_W'(1);
		else if (32'(frame_height_q) > FRAME_HEIGHT_LIMIT) fh = FH_W'(FRAME_HEIGHT_LIMIT);
		else fh = FH_W'(frame_height_q);
	end

	// Shared restoring divider: setup computes fw/bw and fh/bh by repeated
	// subtraction of the shifted divisor; tiles use it for sum/area.
	logic [DV_W-1:0]   dv_rem_q, dv_quo_q;
	logic [AREA_W-1:0] dv_den_q;
	logic [$clog2(DIVSTEPS+1)-1:0] dv_cnt_q;
	logic [1:0] dv_job_q; // 0 cols, 1 rows (setup), 2 channel division
	logic [FW_W-1:0] ncols_q;
	logic [FH_W-1:0] nrows_q;
	logic [FW_W+TS_W-1:0] colspan_q;
	logic [FH_W+TS_W-1:0] rowspan_q;
	logic [AREA_W-1:0] area_q;
	logic [1:0] ch_q; // channel under division
	logic [LANE_W-1:0] lane_val [3];
	logic [7:0] pooled_q [3];
	logic [ACC_W-1:0] acc_wr;

	logic [DV_W+AREA_W-1:0] trial;
	logic [DV_W-1:0] rem_shift;
	logic bit_in;
	always_comb begin
		bit_in    = dv_quo_q[DV_W-1];
		trial     = {{AREA_W{1'b0}}, dv_rem_q[DV_W-2:0], bit_in};
		rem_shift = {dv_rem_q[DV_W-2:0], bit_in};
	end
	// dv_rem holds partial remainder, dv_quo shifts dividend out / quotient in
	wire take = trial >= (DV_W+AREA_W)'(dv_den_q);
	wire last_step = dv_cnt_q == ($clog2(DIVSTEPS+1))'(DIVSTEPS - 1);
	logic [DV_W-1:0] quo_next;
	assign quo_next = {dv_quo_q[DV_W-2:0], take};

	logic setup_done_q, div_done_q;
	logic [LANE_W-1:0] next_ch_dividend;
	always_comb begin
		case (ch_q)
			2'd0:    next_ch_dividend = lane_val[1];
			default: next_ch_dividend = lane_val[2];
		endcase
	end

	function automatic logic [7:0] sat8(input logic [LANE_W-1:0] v);
		sat8 = (v > LANE_W'(255)) ? 8'd255 : v[7:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_done_q <= 1'b0;
			div_done_q   <= 1'b0;
			dv_cnt_q     <= '0;
			dv_job_q     <= '0;
			ch_q         <= '0;
		end else begin
			setup_done_q <= 1'b0;
			div_done_q   <= 1'b0;
			if (cmd.setup_start) begin
				dv_job_q <= 2'd0;
				dv_cnt_q <= '0;
				dv_rem_q <= '0;
				dv_quo_q <= DV_W'(fw);
				dv_den_q <= AREA_W'(bw);
				area_q   <= AREA_W'(bw) * AREA_W'(bh);
			end else if (cmd.div_start) begin
				// first lane taken from the sum being written this cycle
				dv_job_q <= 2'd2;
				ch_q     <= 2'd0;
				dv_cnt_q <= '0;
				dv_rem_q <= '0;
				dv_quo_q <= DV_W'(acc_wr[LANE_W-1:0]);
				dv_den_q <= area_q;
			end else if ((cmd.setup_step && !setup_done_q) || (cmd.div_step && !div_done_q)) begin
				dv_rem_q <= take ? DV_W'(trial - (DV_W+AREA_W)'(dv_den_q)) : rem_shift;
				dv_quo_q <= quo_next;
				dv_cnt_q <= dv_cnt_q + 1'b1;
				if (last_step) begin
					dv_cnt_q <= '0;
					dv_rem_q <= '0;
					case (dv_job_q)
						2'd0: begin
							ncols_q   <= FW_W'(quo_next);
							colspan_q <= (FW_W+TS_W)'(quo_next) * (FW_W+TS_W)'(bw);
							dv_job_q  <= 2'd1;
							dv_quo_q  <= DV_W'(fh);
							dv_den_q  <= AREA_W'(bh);
						end
						2'd1: begin
							nrows_q      <= FH_W'(quo_next);
							rowspan_q    <= (FH_W+TS_W)'(quo_next) * (FH_W+TS_W)'(bh);
							setup_done_q <= 1'b1;
						end
						default: begin
							pooled_q[ch_q] <= sat8(LANE_W'(quo_next));
							if (ch_q == 2'd2) begin
								div_done_q <= 1'b1;
							end else begin
								ch_q     <= ch_q + 1'b1;
								dv_quo_q <= DV_W'(next_ch_dividend);
							end
						end
					endcase
				end
			end
		end
	end
	assign sts.setup_done = setup_done_q;
	assign sts.div_done   = div_done_q;

	// position counters
	logic [CW-1:0] src_col_q, out_col_q;
	logic [RW-1:0] src_row_q;
	logic [TI_W-1:0] col_in_tile_q, row_in_tile_q;
	logic active_q, first_q, emit_q, rend_q, fend_q;
	logic [7:0] px_q [3];

	wire active_c = (32'(src_col_q) < 32'(colspan_q)) && (32'(src_row_q) < 32'(rowspan_q));
	wire col_last = 32'(col_in_tile_q) + 1 >= 32'(bw);
	wire row_last = 32'(row_in_tile_q) + 1 >= 32'(bh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q     <= '0;
			src_row_q     <= '0;
			out_col_q     <= '0;
			col_in_tile_q <= '0;
			row_in_tile_q <= '0;
			active_q      <= 1'b0;
			emit_q        <= 1'b0;
		end else if (cmd.take_pixel) begin
			active_q <= active_c;
			first_q  <= col_in_tile_q == '0 && row_in_tile_q == '0;
			emit_q   <= active_c && col_last && row_last;
			rend_q   <= 32'(out_col_q) + 1 >= 32'(ncols_q);
			fend_q   <= 32'(src_row_q) + 1 >= 32'(rowspan_q);
			px_q[0]  <= pixel_red;
			px_q[1]  <= pixel_green;
			px_q[2]  <= pixel_blue;
			if (active_c) begin
				if (col_last) begin
					col_in_tile_q <= '0;
					out_col_q     <= out_col_q + 1'b1;
				end else begin
					col_in_tile_q <= col_in_tile_q + 1'b1;
				end
			end
			if (32'(src_col_q) + 1 >= 32'(fw)) begin
				src_col_q     <= '0;
				out_col_q     <= '0;
				col_in_tile_q <= '0;
				row_in_tile_q <= row_last ? '0 : row_in_tile_q + 1'b1;
				if (32'(src_row_q) + 1 >= 32'(fh)) begin
					src_row_q     <= '0;
					row_in_tile_q <= '0;
				end else begin
					src_row_q <= src_row_q + 1'b1;
				end
			end else begin
				src_col_q <= src_col_q + 1'b1;
			end
		end
	end
	assign sts.active = active_q;
	assign sts.emit   = emit_q;

	// accumulator memory: address latched with the pixel
	logic [CW-1:0] acc_addr_q;
	logic [ACC_W-1:0] acc_rd;
	logic [ACC_W-1:0] acc_new_q;
	always_ff @(posedge clk) begin
		if (cmd.take_pixel) begin
			acc_addr_q <= out_col_q;
		end
		if (cmd.accum) begin
			acc_new_q <= acc_wr;
		end
	end

	rbpd_ram #(.WIDTH(ACC_W), .DEPTH(MAX_FRAME_WIDTH)) u_acc (
		.clk   (clk),
		.we    (cmd.accum),
		.waddr (acc_addr_q),
		.wdata (acc_wr),
		.raddr (cmd.take_pixel ? out_col_q : acc_addr_q),
		.rdata (acc_rd)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [LANE_W-1:0] v;
			logic [LANE_W:0]   s;
			v = first_q ? '0 : acc_rd[k*LANE_W +: LANE_W];
			s = {1'b0, v} + (LANE_W+1)'(px_q[k]);
			if (pool_mode_q) begin
				acc_wr[k*LANE_W +: LANE_W] = s[LANE_W] ? '1 : s[LANE_W-1:0];
			end else begin
				acc_wr[k*LANE_W +: LANE_W] = (LANE_W'(px_q[k]) > v) ? LANE_W'(px_q[k]) : v;
			end
		end
		for (int k = 0; k < 3; k++) begin
			lane_val[k] = acc_new_q[k*LANE_W +: LANE_W];
		end
	end

	// max mode bypasses the division result
	logic [7:0] ch_sel [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ch_sel[k] = pool_mode_q ? pooled_q[k] : sat8(lane_val[k]);
		end
	end

	// gray: weighted sum then /100 as multiply by reciprocal (exact for < 25501)
	logic [14:0] wsum;
	logic [7:0]  gray_v;
	logic [29:0] recip;
	always_comb begin
		wsum   = 15'(ch_sel[0]) * 15'd30 + 15'(ch_sel[1]) * 15'd59 + 15'(ch_sel[2]) * 15'd11;
		recip  = 30'(wsum) * 30'd5243;
		gray_v = recip[26:19];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_red   <= gray_enable_q ? gray_v : ch_sel[0];
			out_green <= gray_enable_q ? gray_v : ch_sel[1];
			out_blue  <= gray_enable_q ? gray_v : ch_sel[2];
			row_end   <= rend_q;
			frame_end <= rend_q && fend_q;
		end
	end
endmodule

// File: rtl/rgb_block_pool_downscale_core.sv
// Top level of the RGB block-pool downscaler.
`timescale 1ns / 1ps
// Reduces each block_width x block_height tile of a raster RGB stream to one
// pixel (per-channel max or floor average, optional weighted gray). One pixel
// transaction is handled at a time: a pixel inside the tiled area goes through
// accept, accumulator read, read-modify-write and return to idle, one past the
// last whole tile through accept, accumulator read and return to idle. After
// a tile's last pixel the shared bit-serial divider works through the three
// channels in turn, then the result is loaded into the output register. That
// register frees the input side, so a waiting result only stalls the next
// tile's last pixel. After reset or any config write, tile/frame bounds are
// recomputed by the same divider before input is accepted again.
module rgb_block_pool_downscale_core import rbpd_pkg::*; #(
	parameter int MAX_FRAME_WIDTH = DEF_MAX_FRAME_WIDTH,
	parameter int MAX_TILE_SIDE   = DEF_MAX_TILE_SIDE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            pixel_red,
	input  logic [7:0]            pixel_green,
	input  logic [7:0]            pixel_blue,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_red,
	output logic [7:0]            out_green,
	output logic [7:0]            out_blue,
	output logic                  row_end,
	output logic                  frame_end
);
	dp_cmd_t    cmd;
	dp_status_t sts;

	rbpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rbpd_datapath #(
		.MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
		.MAX_TILE_SIDE   (MAX_TILE_SIDE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.row_end     (row_end),
		.frame_end   (frame_end),
		.cmd         (cmd),
		.sts         (sts)
	);
endmodule

// File: verif/tb_rgb_block_pool_downscale_core.sv
// Testbench for rgb_block_pool_downscale_core: checks pooled output against a tile predictor.
`timescale 1ns / 1ps
module tb_rgb_block_pool_downscale_core;
	import rbpd_pkg::*;

	// Watchdog cycle budget.
	localparam int CYCLE_LIMIT = 2_000_000;
	// Drain margin after the last prediction is consumed.
	localparam int DRAIN_CYCLES = 100;
	localparam int SINK_HOLD_CYCLES = 400;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_last;
		logic       frame_last;
	} pooled_px_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            pixel_red = '0;
	logic [7:0]            pixel_green = '0;
	logic [7:0]            pixel_blue = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            out_red;
	logic [7:0]            out_green;
	logic [7:0]            out_blue;
	logic                  row_end;
	logic                  frame_end;

	rgb_block_pool_downscale_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.row_end(row_end), .frame_end(frame_end)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Shadow copy of the block's config and position state
	logic        sh_pool_avg = 1'b0;
	logic        sh_gray = 1'b1;
	logic [4:0]  sh_bw = 5'd5;
	logic [4:0]  sh_bh = 5'd10;
	logic [12:0] sh_fw = 13'd640;
	logic [12:0] sh_fh = 13'd360;
	int unsigned tile_sum [DEF_MAX_FRAME_WIDTH][3];
	int unsigned src_col = 0;
	int unsigned src_row = 0;
	int unsigned col_in_tile = 0;
	int unsigned row_in_tile = 0;
	int unsigned out_col = 0;

	pooled_px_t pending_pixels[$];
	int         error_count = 0;
	int         cycle_count = 0;
	int         src_idle_pct = 0;
	int         snk_idle_pct = 0;
	int         sink_hold = 0;
	logic       hold_req_tgl = 1'b0; // toggled by a test to request a long hold
	logic       hold_seen_q = 1'b0;

	function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Effective (clamped) geometry of the shadow config
	function automatic int unsigned eff_fw();
		return clamp_u(sh_fw, 1, DEF_MAX_FRAME_WIDTH);
	endfunction

	function automatic int unsigned eff_fh();
		return clamp_u(sh_fh, 1, FRAME_HEIGHT_LIMIT);
	endfunction

	// Advance the shadow state by one accepted pixel; queue a result if the
	// pixel closes a tile.
	task automatic predict_downscale(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int unsigned bw, bh, fw, fh, ncols, nrows, idx, v, gray_v;
		int unsigned px[3];
		int unsigned ch[3];
		pooled_px_t res;
		bw = clamp_u(sh_bw, 1, DEF_MAX_TILE_SIDE);
		bh = clamp_u(sh_bh, 1, DEF_MAX_TILE_SIDE);
		fw = eff_fw();
		fh = eff_fh();
		ncols = fw / bw;
		nrows = fh / bh;
		px[0] = r;
		px[1] = g;
		px[2] = b;
		if (src_col < ncols * bw && src_row < nrows * bh) begin
			idx = out_col % DEF_MAX_FRAME_WIDTH;
			for (int k = 0; k < 3; k++) begin
				v = (col_in_tile == 0 && row_in_tile == 0) ? 0 : tile_sum[idx][k];
				if (sh_pool_avg) begin
					v = v + px[k];
					if (v > 16'hFFFF) v = 16'hFFFF;
				end else if (px[k] > v) begin
					v = px[k];
				end
				tile_sum[idx][k] = v;
			end
			if (col_in_tile + 1 >= bw && row_in_tile + 1 >= bh) begin
				for (int k = 0; k < 3; k++) begin
					v = tile_sum[idx][k];
					if (sh_pool_avg) v = v / (bw * bh);
					ch[k] = (v > 255) ? 255 : v;
				end
				if (sh_gray) begin
					gray_v = (ch[0] * 30 + ch[1] * 59 + ch[2] * 11) / 100;
					ch[0] = gray_v;
					ch[1] = gray_v;
					ch[2] = gray_v;
				end
				res.red = ch[0];
				res.green = ch[1];
				res.blue = ch[2];
				res.row_last = (out_col + 1 >= ncols);
				res.frame_last = res.row_last && (src_row + 1 >= nrows * bh);
				pending_pixels.push_back(res);
			end
			if (col_in_tile + 1 >= bw) begin
				col_in_tile = 0;
				out_col = (out_col + 1) & 12'hFFF;
			end else begin
				col_in_tile++;
			end
		end
		if (src_col + 1 >= fw) begin
			src_col = 0;
			out_col = 0;
			col_in_tile = 0;
			row_in_tile = (row_in_tile + 1 >= bh) ? 0 : row_in_tile + 1;
			if (src_row + 1 >= fh) begin
				src_row = 0;
				row_in_tile = 0;
			end else begin
				src_row++;
			end
		end else begin
			src_col++;
		end
	endtask

	// Cycle counter and watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side: random or held-off ready, and the check of every
	// accepted output transaction against the oldest prediction.
	always @(posedge clk) begin
		pooled_px_t exp_px;
		if (hold_req_tgl != hold_seen_q) begin
			hold_seen_q <= hold_req_tgl;
			out_ready <= 1'b0;
			sink_hold <= SINK_HOLD_CYCLES;
		end else if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= snk_idle_pct);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				error_count++;
				$display("%0t: unexpected output rgb=%h/%h/%h row_end=%b frame_end=%b",
					$time, out_red, out_green, out_blue, row_end, frame_end);
			end else begin
				exp_px = pending_pixels.pop_front();
				if (out_red !== exp_px.red || out_green !== exp_px.green ||
						out_blue !== exp_px.blue || row_end !== exp_px.row_last ||
						frame_end !== exp_px.frame_last) begin
					error_count++;
					$display("%0t: mismatch exp rgb=%h/%h/%h re=%b fe=%b got rgb=%h/%h/%h re=%b fe=%b",
						$time, exp_px.red, exp_px.green, exp_px.blue,
						exp_px.row_last, exp_px.frame_last,
						out_red, out_green, out_blue, row_end, frame_end);
				end
			end
		end
	end

	// Sends one pixel transaction; valid stays high afterward so back-to-back
	// pixels never see a low/high pair in one step. wait_idle drops it.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_red <= r;
		pixel_green <= g;
		pixel_blue <= b;
		do @(posedge clk); while (!in_ready);
		predict_downscale(r, g, b);
	endtask

	function automatic logic [7:0] rand_channel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Drain all predictions plus a margin for a pixel still in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write enable stays high across back-to-back writes; caller drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		case (idx)
			REG_POOL_MODE:    sh_pool_avg = val[0];
			REG_GRAY_ENABLE:  sh_gray = val[0];
			REG_BLOCK_WIDTH:  sh_bw = val[4:0];
			REG_BLOCK_HEIGHT: sh_bh = val[4:0];
			REG_FRAME_WIDTH:  sh_fw = val[12:0];
			REG_FRAME_HEIGHT: sh_fh = val[12:0];
			default: ;
		endcase
	endtask

	// Reconfigure at a frame boundary only, so no stale tile entry is ever read
	task automatic set_geometry(input int unsigned avg, input int unsigned gray,
			input int unsigned bw, input int unsigned bh,
			input int unsigned fw, input int unsigned fh);
		wait_idle();
		write_reg(REG_POOL_MODE, avg);
		write_reg(REG_GRAY_ENABLE, gray);
		write_reg(REG_BLOCK_WIDTH, bw);
		write_reg(REG_BLOCK_HEIGHT, bh);
		write_reg(REG_FRAME_WIDTH, fw);
		write_reg(REG_FRAME_HEIGHT, fh);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame();
		int unsigned n;
		n = eff_fw() * eff_fh();
		for (int unsigned i = 0; i < n; i++)
			send_pixel(rand_channel(), rand_channel(), rand_channel());
	endtask

	// 2x2 tiles over a 4x2 frame with full-scale patterns, in each mode
	task automatic test_directed_modes();
		logic [7:0] pat [8][3] = '{
			'{8'h00, 8'hFF, 8'h01}, '{8'hFF, 8'h00, 8'h80},
			'{8'h7F, 8'h7F, 8'h7F}, '{8'h00, 8'h00, 8'h00},
			'{8'h80, 8'h01, 8'hFE}, '{8'hFF, 8'hFF, 8'hFF},
			'{8'h01, 8'h80, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}};
		for (int m = 0; m < 3; m++) begin
			set_geometry(m != 0, m == 2, 2, 2, 4, 2);
			for (int i = 0; i < 8; i++)
				send_pixel(pat[i][0], pat[i][1], pat[i][2]);
		end
	endtask

	// Tile sides of zero and above the maximum clamp to 1 and 16
	task automatic test_tile_clamping();
		set_geometry(1, 0, 0, 31, 3, 16);
		send_frame();
		set_geometry(0, 1, 31, 0, 33, 1);
		send_frame();
	endtask

	// Frame smaller than a tile gives nothing; zero frame size acts as 1x1
	task automatic test_tiny_frames();
		set_geometry(0, 0, 4, 4, 3, 2);
		send_frame();
		set_geometry(1, 1, 1, 1, 0, 0);
		repeat (3) send_pixel(rand_channel(), rand_channel(), rand_channel());
	endtask

	// Largest tile in average mode, where lane sums use all 16 bits; then an
	// oversize frame height, cut short by a lower height that ends the frame
	// on the next pixel, which lies below the last whole tile
	task automatic test_extreme_frames();
		set_geometry(1, 0, 16, 16, 16, 16);
		send_frame();
		set_geometry(1, 1, 1, 16, 1, 8191);
		repeat (32) send_pixel(rand_channel(), rand_channel(), rand_channel());
		set_geometry(1, 1, 1, 16, 1, 33);
		send_pixel(rand_channel(), rand_channel(), rand_channel());
	endtask

	// Receiver stalls for a long stretch while pixels keep coming
	task automatic test_output_stall();
		set_geometry(0, 0, 1, 1, 8, 4);
		hold_req_tgl = ~hold_req_tgl;
		send_frame();
	endtask

	// Random geometry and content, mostly small tiles and frames
	task automatic test_random_frames(input int unsigned target);
		int unsigned sent;
		int unsigned bw, bh;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(9) == 0) begin
				bw = 16;
				bh = $urandom_range(1, 2);
			end else begin
				bw = $urandom_range(1, 4);
				bh = $urandom_range(1, 4);
			end
			if ($urandom_range(11) == 0)
				set_geometry($urandom_range(1), $urandom_range(1), bw, bh,
					$urandom_range(1, bw), $urandom_range(1, bh));
			else
				set_geometry($urandom_range(1), $urandom_range(1), bw, bh,
					bw * $urandom_range(1, 4) + $urandom_range(0, bw - 1),
					bh * $urandom_range(1, 3) + $urandom_range(0, bh - 1));
			sent += eff_fw() * eff_fh();
			send_frame();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_modes();
		test_tile_clamping();
		test_tiny_frames();
		test_extreme_frames();
		test_output_stall();

		src_idle_pct = 25;
		snk_idle_pct = 45;
		test_random_frames(150);
		src_idle_pct = 45;
		snk_idle_pct = 25;
		test_random_frames(150);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_frames(150);

		wait_idle();
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
